// ----- rtl/rpt_pkg.sv -----
// Package: beat types, field widths and register codes of the recovery probability tracker.
`timescale 1ns / 1ps
`default_nettype none

package rpt_pkg;

  localparam int unsigned QUAL_W  = 32;
  localparam int unsigned ALPHA_W = 17;
  localparam int unsigned AVG_W   = 31;
  localparam int unsigned PROB_W  = 17;

  localparam int unsigned ADDR_W  = 3;
  localparam int unsigned DATA_W  = 32;

  // register index, taken from paddr[2]
  localparam logic REG_ALPHA_SLOW = 1'b0;
  localparam logic REG_ALPHA_FAST = 1'b1;

  typedef struct packed {
    logic signed [QUAL_W-1:0] quality;
    logic                     quality_valid;
  } in_t;

  typedef struct packed {
    logic [PROB_W-1:0] recovery_prob;
    logic [AVG_W-1:0]  slow_average;
    logic [AVG_W-1:0]  fast_average;
  } out_t;

endpackage

`default_nettype wire

// ----- rtl/recovery_probability_tracker.sv -----
// Top level: slow/fast quality averages and recovery probability, shared multiplier and divider.
`timescale 1ns / 1ps
`default_nettype none

// Takes one quality beat at a time and returns one result beat. With both
// gains nonzero and a nonzero slow average, an accepted beat passes through
// two multiply/update pairs on one multiplier, a divider setup state, and a
// restoring divider that yields one quotient bit per cycle, after which the
// result beat is offered. A beat that loads the averages directly skips
// both multiply/update pairs. The divider is skipped when the fast average
// is not below the slow one. With a zero gain the result is offered the
// cycle after acceptance. in_stall_o stays high until the result beat has
// been taken, so no new beat is accepted while a result beat is pending.
module recovery_probability_tracker
  import rpt_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire               clk_i,
  input  wire               rst_ni,

  input  wire               in_valid_i,
  output logic              in_stall_o,
  input  in_t               in_data_i,

  output logic              out_valid_o,
  input  wire               out_stall_i,
  output out_t              out_data_o,

  input  wire               psel,
  input  wire               penable,
  input  wire               pwrite,
  input  wire  [ADDR_W-1:0] paddr,
  input  wire  [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int unsigned AW  = (FRAC_BITS + 1 > ALPHA_W) ? FRAC_BITS + 1 : ALPHA_W;
  localparam int unsigned PW  = AVG_W + AW;
  localparam int unsigned CW  = $clog2(FRAC_BITS);
  localparam logic [AW-1:0] ONE = {{(AW-1){1'b0}}, 1'b1} << FRAC_BITS;
  localparam logic [CW-1:0] CNT_LAST = CW'(FRAC_BITS - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MULS = 3'd1;
  localparam logic [2:0] S_ADDS = 3'd2;
  localparam logic [2:0] S_MULF = 3'd3;
  localparam logic [2:0] S_ADDF = 3'd4;
  localparam logic [2:0] S_DIVI = 3'd5;
  localparam logic [2:0] S_DIV  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0]           state_q, state_d;
  logic [ALPHA_W-1:0]   alpha_s_q, alpha_f_q;
  logic [AVG_W-1:0]     slow_q, slow_d, fast_q, fast_d;
  logic [AVG_W-1:0]     q_q, q_d;
  logic [PW-1:0]        prod_q, prod_d;
  logic                 dn_q, dn_d;
  logic [AVG_W:0]       rem_q, rem_d;
  logic [FRAC_BITS:0]   quot_q, quot_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic                 out_valid_q, out_valid_d;
  out_t                 out_q, out_d;

  logic                 in_acc, out_acc, cfg_wr;
  logic [AVG_W-1:0]     q_in;
  logic [AVG_W-1:0]     avg_op, mag;
  logic [AW-1:0]        alpha_ext, alpha_sat;
  logic                 up;
  logic [PW:0]          rnd;
  logic [AVG_W-1:0]     step_up, step_dn, new_avg;
  logic [AVG_W:0]       rem_sh;
  logic                 ge;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;
  assign cfg_wr  = psel && penable && pwrite && pready;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign pready      = 1'b1;

  always_comb begin
    case (paddr[2])
      REG_ALPHA_SLOW: prdata = DATA_W'(alpha_s_q);
      REG_ALPHA_FAST: prdata = DATA_W'(alpha_f_q);
      default:        prdata = '0;
    endcase
  end

  assign q_in = (!in_data_i.quality_valid || in_data_i.quality[QUAL_W-1]) ? '0 :
                in_data_i.quality[AVG_W-1:0];

  // shared multiplier operands
  assign avg_op    = (state_q == S_MULS || state_q == S_ADDS) ? slow_q : fast_q;
  assign alpha_ext = (state_q == S_MULS) ? AW'(alpha_s_q) : AW'(alpha_f_q);
  assign alpha_sat = (alpha_ext > ONE) ? ONE : alpha_ext;
  assign up        = (q_q >= avg_op);
  assign mag       = up ? (q_q - avg_op) : (avg_op - q_q);

  // update from the registered product; a downward move rounds the step up
  assign rnd     = {1'b0, prod_q} + (PW + 1)'(ONE - 1'b1);
  assign step_up = prod_q[FRAC_BITS +: AVG_W];
  assign step_dn = rnd[FRAC_BITS +: AVG_W];
  assign new_avg = dn_q ? (avg_op - step_dn) : (avg_op + step_up);

  assign rem_sh = {rem_q[AVG_W-1:0], 1'b0};
  assign ge     = (rem_sh >= {1'b0, slow_q});

  always_comb begin
    state_d     = state_q;
    slow_d      = slow_q;
    fast_d      = fast_q;
    q_d         = q_q;
    prod_d      = prod_q;
    dn_d        = dn_q;
    rem_d       = rem_q;
    quot_d      = quot_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          q_d = q_in;
          if (alpha_s_q == '0 || alpha_f_q == '0) begin
            slow_d      = '0;
            fast_d      = '0;
            out_d       = '0;
            out_valid_d = 1'b1;
            state_d     = S_OUT;
          end else if (slow_q == '0) begin
            slow_d  = q_in;
            fast_d  = q_in;
            state_d = S_DIVI;
          end else begin
            state_d = S_MULS;
          end
        end
      end
      S_MULS, S_MULF: begin
        prod_d  = PW'(mag) * PW'(alpha_sat);
        dn_d    = !up;
        state_d = (state_q == S_MULS) ? S_ADDS : S_ADDF;
      end
      S_ADDS: begin
        slow_d  = new_avg;
        state_d = S_MULF;
      end
      S_ADDF: begin
        fast_d  = new_avg;
        state_d = S_DIVI;
      end
      S_DIVI: begin
        // zero fast average gives exactly 1.0: integer bit set up front
        quot_d = {{FRAC_BITS{1'b0}}, fast_q == '0};
        cnt_d  = '0;
        rem_d  = (fast_q == '0) ? '0 : {1'b0, slow_q - fast_q};
        if (slow_q != '0 && fast_q < slow_q) begin
          state_d = S_DIV;
        end else begin
          out_d       = '{recovery_prob: '0, slow_average: slow_q, fast_average: fast_q};
          out_valid_d = 1'b1;
          state_d     = S_OUT;
        end
      end
      S_DIV: begin
        rem_d  = ge ? (rem_sh - {1'b0, slow_q}) : rem_sh;
        quot_d = {quot_q[FRAC_BITS-1:0], ge};
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          out_d = '{recovery_prob: PROB_W'({quot_q[FRAC_BITS-1:0], ge}),
                    slow_average: slow_q, fast_average: fast_q};
          out_valid_d = 1'b1;
          state_d     = S_OUT;
        end
      end
      S_OUT: begin
        if (out_acc) begin
          out_valid_d = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      alpha_s_q   <= '0;
      alpha_f_q   <= '0;
      slow_q      <= '0;
      fast_q      <= '0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      slow_q      <= slow_d;
      fast_q      <= fast_d;
      cnt_q       <= cnt_d;
      if (cfg_wr) begin
        case (paddr[2])
          REG_ALPHA_SLOW: alpha_s_q <= pwdata[ALPHA_W-1:0];
          REG_ALPHA_FAST: alpha_f_q <= pwdata[ALPHA_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    q_q    <= q_d;
    prod_q <= prod_d;
    dn_q   <= dn_d;
    rem_q  <= rem_d;
    quot_q <= quot_d;
    out_q  <= out_d;
  end

  a_out_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while a result beat is pending");

  a_no_prob_without_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.fast_average >= out_data_o.slow_average)
      |-> out_data_o.recovery_prob == '0)
    else $error("nonzero probability with fast average not below slow");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (rem_q < {1'b0, slow_q}))
    else $error("divider remainder out of range");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q != S_IDLE))
    else $error("accepted beat did not start the sequencer");

endmodule

`default_nettype wire
